@@ rtl/subtitle_tag_stripper_assert.svh @@
// assertion helpers for the subtitle tag stripper
// the including module provides clk and rst
`ifndef SUBTITLE_TAG_STRIPPER_ASSERT_SVH
`define SUBTITLE_TAG_STRIPPER_ASSERT_SVH

// same-cycle implication
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sts_pkg.sv @@
package sts_pkg;

  // item kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_H   = 8'h68;
  localparam logic [7:0] CH_LO_P   = 8'h70;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // capacity after reset
  localparam logic [15:0] CAP_RESET = 16'd499;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last;
    logic        tag_overflow;
    logic [15:0] bytes_kept;
  } out_item_t;

endpackage

@@ rtl/sts_tag_mem.sv @@
module sts_tag_mem #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sts_out_buf.sv @@
module sts_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sts_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output sts_pkg::out_item_t out_item
);
  import sts_pkg::*;

  out_item_t slots [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] cnt;
  logic      pop;

  assign pop       = out_valid && out_ready;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

@@ rtl/subtitle_tag_stripper.sv @@
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_item (kind, in_byte)
// out       output     out_valid / out_ready out_item (out_byte .. bytes_kept)
// cfg       input      cfg_we                cfg_wdata (out_capacity)
//
// a text item giving two results emits the second one from the S_SECOND state
// end of string replays the stored tag bytes, each one read from the tag store
// in S_RD and emitted in S_EMIT
// rst is synchronous active high, clears parse state and count, sets capacity to 499
// a two-entry output buffer holds results; input stalls only while it is full
// or while the block is still emitting results of an earlier item
`include "subtitle_tag_stripper_assert.svh"

module subtitle_tag_stripper #(
  parameter int TAG_DEPTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sts_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import sts_pkg::*;

  localparam int LW = $clog2(TAG_DEPTH + 1);
  localparam int AW = $clog2(TAG_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SECOND = 4'b0010,
    S_RD     = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic        inside_tag, inside_tag_next;
  logic        drawing, drawing_next;
  logic        text_bs, text_bs_next;
  logic        tag_bs, tag_bs_next;
  logic        digits, digits_next;
  logic [15:0] count, count_next;
  logic [15:0] capacity;
  logic [LW-1:0] tag_len, tag_len_next;
  logic        tag_ovf, tag_ovf_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [LW-1:0] rep_len, rep_len_next;
  logic        rep_ovf, rep_ovf_next;
  logic [LW-1:0] idx, idx_next;

  logic        accept;
  logic        full;
  logic        below;
  logic [15:0] count_inc;
  logic [LW-1:0] idx_inc;

  logic        emit_req;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_ovf;
  logic        bare_req;
  logic        push;
  out_item_t   push_item;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign in_ready  = (state == S_IDLE) && !full;
  assign accept    = in_valid && in_ready;
  assign below     = (count < capacity);
  assign count_inc = count + 16'd1;
  assign idx_inc   = idx + LW'(1);

  // parser and replay sequencer
  always_comb begin
    logic [7:0] b;
    logic       handled;
    logic       second;
    logic       bs_emit;
    logic [LW-1:0] rlen;
    logic       ovf_e;
    b               = in_item.in_byte;
    handled         = 1'b0;
    second          = 1'b0;
    bs_emit         = 1'b0;
    rlen            = '0;
    ovf_e           = 1'b0;
    state_next      = state;
    inside_tag_next = inside_tag;
    drawing_next    = drawing;
    text_bs_next    = text_bs;
    tag_bs_next     = tag_bs;
    digits_next     = digits;
    count_next      = count;
    tag_len_next    = tag_len;
    tag_ovf_next    = tag_ovf;
    held_byte_next  = held_byte;
    rep_len_next    = rep_len;
    rep_ovf_next    = rep_ovf;
    idx_next        = idx;
    emit_req        = 1'b0;
    emit_byte       = '0;
    emit_last       = 1'b0;
    emit_ovf        = 1'b0;
    bare_req        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = b;
    mem_re          = 1'b0;
    mem_raddr       = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            KIND_TEXT: begin
              if (inside_tag) begin
                // store the tag byte while there is room
                if (tag_len < LW'(TAG_DEPTH)) begin
                  mem_we       = 1'b1;
                  mem_waddr    = tag_len[AW-1:0];
                  tag_len_next = tag_len + LW'(1);
                end else begin
                  tag_ovf_next = 1'b1;
                end
                if (digits && b >= CH_ZERO && b <= CH_NINE) begin
                  if (b != CH_ZERO) begin
                    drawing_next = 1'b1;
                  end
                end else begin
                  digits_next = 1'b0;
                  if (tag_bs && b == CH_LO_P) begin
                    tag_bs_next  = 1'b0;
                    drawing_next = 1'b0;
                    digits_next  = 1'b1;
                  end else begin
                    tag_bs_next = 1'b0;
                    if (b == CH_RBRACE) begin
                      inside_tag_next = 1'b0;
                    end else if (b == CH_BSLASH) begin
                      tag_bs_next = 1'b1;
                    end
                  end
                end
              end else begin
                // resolve a pending escape first
                if (text_bs) begin
                  text_bs_next = 1'b0;
                  if (b == CH_UP_N || b == CH_LO_N) begin
                    emit_req  = 1'b1;
                    emit_byte = CH_NL;
                    handled   = 1'b1;
                  end else if (b == CH_LO_H) begin
                    emit_req  = 1'b1;
                    emit_byte = CH_SPACE;
                    handled   = 1'b1;
                  end else if (!drawing) begin
                    emit_req  = 1'b1;
                    emit_byte = CH_BSLASH;
                    second    = 1'b1;
                  end
                end
                if (!handled) begin
                  if (b == CH_BSLASH) begin
                    text_bs_next = 1'b1;
                  end else if (b == CH_LBRACE) begin
                    inside_tag_next = 1'b1;
                    tag_ovf_next    = 1'b0;
                    mem_we          = 1'b1;
                    mem_waddr       = '0;
                    tag_len_next    = LW'(1);
                  end else if (!drawing) begin
                    if (second) begin
                      held_byte_next = b;
                      state_next     = S_SECOND;
                    end else begin
                      emit_req  = 1'b1;
                      emit_byte = b;
                    end
                  end
                end
              end
            end
            KIND_END: begin
              bs_emit      = text_bs && !drawing;
              rlen         = inside_tag ? tag_len : '0;
              ovf_e        = inside_tag && tag_ovf;
              rep_len_next = rlen;
              rep_ovf_next = ovf_e;
              idx_next     = '0;
              emit_ovf     = ovf_e;
              if (!below || (!bs_emit && rlen == '0)) begin
                bare_req  = 1'b1;
                emit_last = 1'b1;
              end else if (bs_emit) begin
                emit_req  = 1'b1;
                emit_byte = CH_BSLASH;
                emit_last = (rlen == '0) || (count_inc == capacity);
                if (!emit_last) begin
                  state_next = S_RD;
                end
              end else begin
                state_next = S_RD;
              end
              // parse state back to reset
              inside_tag_next = 1'b0;
              drawing_next    = 1'b0;
              text_bs_next    = 1'b0;
              tag_bs_next     = 1'b0;
              digits_next     = 1'b0;
              tag_len_next    = '0;
              tag_ovf_next    = 1'b0;
            end
            KIND_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SECOND: begin
        // byte that followed a plain backslash
        if (!full) begin
          emit_req   = 1'b1;
          emit_byte  = held_byte;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!full) begin
          emit_req  = 1'b1;
          emit_byte = mem_rdata;
          emit_ovf  = rep_ovf;
          emit_last = (idx_inc == rep_len) || (count_inc == capacity);
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // kept bytes advance the count
    if (emit_req && below) begin
      count_next = count_inc;
    end
  end

  // result formation
  assign push = bare_req || (emit_req && below);
  always_comb begin
    push_item.out_byte     = bare_req ? 8'd0 : emit_byte;
    push_item.has_byte     = !bare_req;
    push_item.last         = emit_last;
    push_item.tag_overflow = emit_ovf;
    push_item.bytes_kept   = bare_req ? count : count_inc;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      inside_tag <= 1'b0;
      drawing    <= 1'b0;
      text_bs    <= 1'b0;
      tag_bs     <= 1'b0;
      digits     <= 1'b0;
      count      <= '0;
      tag_len    <= '0;
      tag_ovf    <= 1'b0;
      capacity   <= CAP_RESET;
    end else begin
      state      <= state_next;
      inside_tag <= inside_tag_next;
      drawing    <= drawing_next;
      text_bs    <= text_bs_next;
      tag_bs     <= tag_bs_next;
      digits     <= digits_next;
      count      <= count_next;
      tag_len    <= tag_len_next;
      tag_ovf    <= tag_ovf_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // replay bookkeeping
  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    rep_len   <= rep_len_next;
    rep_ovf   <= rep_ovf_next;
    idx       <= idx_next;
  end

  sts_tag_mem #(
    .DEPTH (TAG_DEPTH),
    .AW    (AW)
  ) u_tag_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sts_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // checks
  `STS_ASSERT_IMP(a_no_push_full, push, !full, "result pushed into a full buffer")
  `STS_ASSERT_IMP(a_kept_below_cap, push && push_item.has_byte, count < capacity,
    "byte kept past capacity")
  `STS_ASSERT_NXT(a_last_ends_item, push && push_item.last, state == S_IDLE,
    "sequencer busy after final result")
  `STS_ASSERT_IMP(a_store_write_idle, mem_we, state == S_IDLE && !mem_re,
    "tag store written during replay")
  `STS_ASSERT_IMP(a_len_bound, tag_len != '0, tag_len <= LW'(TAG_DEPTH),
    "tag length beyond store depth")

endmodule

@@ tb/tb_subtitle_tag_stripper.sv @@
`timescale 1ns / 1ps

module tb_subtitle_tag_stripper;
  import sts_pkg::*;

  localparam int TAG_DEPTH = 48;
  localparam int TAG_AW = $clog2(TAG_DEPTH);
  // kind value the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // end of string may replay a full tag, one store read and one result per byte
  localparam int SETTLE_CYCLES = 2 * TAG_DEPTH + 24;
  localparam int LONG_HOLD = 300;
  // cycles with no item moving on either side; well above the long hold
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  subtitle_tag_stripper #(
    .TAG_DEPTH(TAG_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // items waiting to be sent and plain text expected back
  in_item_t subtitle_in_q[$];
  out_item_t plain_out_q[$];
  int queued_total = 0;
  int bad_results = 0;

  // shadow of the stripper state
  logic [15:0] cap_setting = CAP_RESET;
  logic [15:0] kept_count = '0;
  logic in_tag = 1'b0;
  logic drawing = 1'b0;
  logic text_bs = 1'b0;
  logic tag_bs = 1'b0;
  logic in_digits = 1'b0;
  logic [7:0] tag_bytes [0:TAG_DEPTH-1];
  int tag_len = 0;
  logic tag_spilled = 1'b0;

  // flow control between the sequencer and the driver / receiver
  logic send_hold = 1'b0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [7:0] ready_pattern = 8'hFF;
  int pattern_age = 0;
  int quiet_cycles = 0;

  // one output byte counted against capacity
  function automatic void keep_char(logic [7:0] b, logic ovf);
    out_item_t r;
    if (kept_count < cap_setting) begin
      kept_count = kept_count + 16'd1;
      r.out_byte = b;
      r.has_byte = 1'b1;
      r.last = 1'b0;
      r.tag_overflow = ovf;
      r.bytes_kept = kept_count;
      plain_out_q.push_back(r);
    end
  endfunction

  // expected plain text for one accepted item
  task automatic strip_item(input in_item_t it);
    logic [7:0] b;
    logic ovf;
    logic fresh;
    int n_before;
    out_item_t r;
    b = it.in_byte;
    case (it.kind)
      KIND_TEXT: begin
        if (in_tag) begin
          // inside a tag: store, then parse override codes
          if (tag_len < TAG_DEPTH) begin
            tag_bytes[TAG_AW'(tag_len)] = b;
            tag_len++;
          end else begin
            tag_spilled = 1'b1;
          end
          if (in_digits && b >= CH_ZERO && b <= CH_NINE) begin
            if (b != CH_ZERO) drawing = 1'b1;
          end else begin
            in_digits = 1'b0;
            if (tag_bs && b == CH_LO_P) begin
              tag_bs = 1'b0;
              drawing = 1'b0;
              in_digits = 1'b1;
            end else begin
              tag_bs = 1'b0;
              if (b == CH_RBRACE) in_tag = 1'b0;
              else if (b == CH_BSLASH) tag_bs = 1'b1;
            end
          end
        end else begin
          // plain text with escapes
          fresh = 1'b1;
          if (text_bs) begin
            text_bs = 1'b0;
            if (b == CH_UP_N || b == CH_LO_N) begin
              keep_char(CH_NL, 1'b0);
              fresh = 1'b0;
            end else if (b == CH_LO_H) begin
              keep_char(CH_SPACE, 1'b0);
              fresh = 1'b0;
            end else if (!drawing) begin
              keep_char(CH_BSLASH, 1'b0);
            end
          end
          if (fresh) begin
            if (b == CH_BSLASH) begin
              text_bs = 1'b1;
            end else if (b == CH_LBRACE) begin
              in_tag = 1'b1;
              tag_spilled = 1'b0;
              tag_bytes[0] = CH_LBRACE;
              tag_len = 1;
            end else if (!drawing) begin
              keep_char(b, 1'b0);
            end
          end
        end
      end
      KIND_END: begin
        ovf = in_tag && tag_spilled;
        n_before = plain_out_q.size();
        if (text_bs && !drawing) keep_char(CH_BSLASH, ovf);
        if (in_tag) begin
          for (int i = 0; i < tag_len; i++) keep_char(tag_bytes[TAG_AW'(i)], ovf);
        end
        if (plain_out_q.size() == n_before) begin
          r.out_byte = '0;
          r.has_byte = 1'b0;
          r.last = 1'b1;
          r.tag_overflow = ovf;
          r.bytes_kept = kept_count;
          plain_out_q.push_back(r);
        end else begin
          r = plain_out_q.pop_back();
          r.last = 1'b1;
          plain_out_q.push_back(r);
        end
        in_tag = 1'b0;
        drawing = 1'b0;
        text_bs = 1'b0;
        tag_bs = 1'b0;
        in_digits = 1'b0;
        tag_len = 0;
        tag_spilled = 1'b0;
      end
      KIND_CLEAR: begin
        kept_count = '0;
      end
      default: begin
      end
    endcase
  endtask

  // stimulus building
  task automatic push_item(logic [1:0] k, logic [7:0] b);
    in_item_t it;
    it.kind = k;
    it.in_byte = b;
    subtitle_in_q.push_back(it);
    queued_total++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_item(KIND_TEXT, s[i]);
  endtask

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'($urandom_range(8'h61, 8'h7A));
      4, 5: b = 8'($urandom_range(0, 255));
      6: b = CH_BSLASH;
      7: begin
        case ($urandom_range(0, 3))
          0: b = CH_UP_N;
          1: b = CH_LO_N;
          2: b = CH_LO_H;
          default: b = CH_LO_P;
        endcase
      end
      8: b = $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE;
      default: b = 8'($urandom_range(CH_ZERO, CH_NINE));
    endcase
    return b;
  endfunction

  // backslash-p with zero to three digits, zeros favored
  task automatic push_draw_code();
    logic [7:0] d;
    push_item(KIND_TEXT, CH_BSLASH);
    push_item(KIND_TEXT, CH_LO_P);
    repeat ($urandom_range(0, 3)) begin
      d = $urandom_range(0, 2) == 0 ? CH_ZERO
                                    : 8'($urandom_range(CH_ZERO, CH_NINE));
      push_item(KIND_TEXT, d);
    end
  endtask

  task automatic push_tag(logic closed, logic longer);
    push_item(KIND_TEXT, CH_LBRACE);
    if (longer) begin
      // uppercase letters after an optional drawing code, so the tag can run past the store
      if ($urandom_range(0, 1)) push_draw_code();
      repeat ($urandom_range(44, 60)) begin
        push_item(KIND_TEXT, 8'($urandom_range(8'h41, 8'h5A)));
      end
    end else begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 3))
          0: push_draw_code();
          1: begin
            push_item(KIND_TEXT, CH_BSLASH);
            push_item(KIND_TEXT, rand_text_byte());
          end
          default: push_item(KIND_TEXT, rand_text_byte());
        endcase
      end
    end
    if (closed) push_item(KIND_TEXT, CH_RBRACE);
  endtask

  // one subtitle line: text, escapes, tags and a little noise
  task automatic push_line();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_item(KIND_TEXT, rand_text_byte());
        4, 5: begin
          push_item(KIND_TEXT, CH_BSLASH);
          push_item(KIND_TEXT, rand_text_byte());
        end
        6, 7: push_tag($urandom_range(0, 4) != 0, $urandom_range(0, 11) == 0);
        8: begin
          push_item(KIND_TEXT, CH_LBRACE);
          push_draw_code();
          push_item(KIND_TEXT, CH_RBRACE);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: push_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
            1: push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            default: push_item(KIND_END, 8'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_lines(int n);
    int target;
    target = queued_total + n;
    while (queued_total < target) push_line();
  endtask

  // wait for every item sent and every result back, then let the block settle
  task automatic drain();
    while (subtitle_in_q.size() > 0 || in_valid || plain_out_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cap_setting = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver: bursts with random gaps
  always @(posedge clk) begin : drive_input
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        strip_item(in_item);
        void'(subtitle_in_q.pop_front());
      end
      offer = 1'b0;
      if (in_valid && !in_ready) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (subtitle_in_q.size() > 0 && !send_hold) begin
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
          gap_left = burst_left > 30 ? 0 : $urandom_range(0, 6);
        end
      end
      in_valid <= offer;
      if (offer) in_item <= subtitle_in_q[0];
    end
  end

  // receiver: rotating stall pattern, plus long holds on request
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count--;
      out_ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_count = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        ready_pattern = $urandom_range(0, 2) == 0 ? 8'hFF
                                                  : (8'($urandom_range(0, 255)) | 8'h01);
        pattern_age = $urandom_range(16, 96);
      end else begin
        pattern_age--;
      end
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
    end
  end

  // output checker
  always @(posedge clk) begin : check_output
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (plain_out_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: byte %02h has %0d last %0d ovf %0d kept %0d",
                   out_item.out_byte, out_item.has_byte, out_item.last,
                   out_item.tag_overflow, out_item.bytes_kept);
      end else begin
        want = plain_out_q.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.has_byte !== want.has_byte ||
            out_item.last !== want.last || out_item.tag_overflow !== want.tag_overflow ||
            out_item.bytes_kept !== want.bytes_kept) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected %02h %0d %0d %0d %0d, got %02h %0d %0d %0d %0d",
                     want.out_byte, want.has_byte, want.last, want.tag_overflow,
                     want.bytes_kept, out_item.out_byte, out_item.has_byte,
                     out_item.last, out_item.tag_overflow, out_item.bytes_kept);
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_subtitle_tag_stripper failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin : run_test
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, escapes, drawing, pending backslash, clear, unused kind
    push_str("A");
    push_item(KIND_TEXT, 8'h00);
    push_item(KIND_TEXT, 8'hFF);
    push_str("\\N\\h\\q");
    push_str("{\\p1}z\\n\\");
    push_item(KIND_END, 8'h00);
    push_str("\\");
    push_item(KIND_END, 8'hFF);
    push_item(KIND_CLEAR, 8'hA5);
    push_item(KIND_UNUSED, 8'h5A);
    push_str("{b");
    push_item(KIND_END, 8'h00);
    drain();

    // nothing kept: every end gives a bare marker
    write_capacity(16'd0);
    push_lines(20);
    drain();

    // full capacity: tag overflow, exact fill, long receiver hold, sender pause
    write_capacity(16'hFFFF);
    holds_asked++;
    push_item(KIND_TEXT, CH_LBRACE);
    repeat (52) push_item(KIND_TEXT, 8'($urandom_range(8'h61, 8'h7A)));
    push_item(KIND_END, 8'h00);
    push_item(KIND_TEXT, CH_LBRACE);
    repeat (TAG_DEPTH - 1) push_item(KIND_TEXT, 8'($urandom_range(8'h61, 8'h7A)));
    push_item(KIND_END, 8'h00);
    push_lines(20);
    while (subtitle_in_q.size() > 10) @(posedge clk);
    send_hold = 1'b1;
    while (in_valid || plain_out_q.size() > 0) @(posedge clk);
    send_hold = 1'b0;
    push_lines(20);
    drain();

    // small capacity: limit reached often, clear items reopen it
    write_capacity(16'($urandom_range(1, 40)));
    push_lines(55);
    drain();

    write_capacity(16'($urandom_range(0, 65535)));
    push_lines(30);
    drain();

    write_capacity(CAP_RESET);
    push_lines(35);
    drain();

    if (bad_results == 0 && plain_out_q.size() == 0) begin
      $display("tb_subtitle_tag_stripper passed");
    end else begin
      $display("tb_subtitle_tag_stripper failed");
    end
    $finish;
  end

endmodule
